// ===== rtl/core/assert_macros.svh =====
//------------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the generator RTL.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed: invariant");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/mtg_pkg.sv =====
//------------------------------------------------------------------------------
// mtg_pkg
// Constants, unit opcodes and request type for the MT19937 generator.
//------------------------------------------------------------------------------
package mtg_pkg;

    // state geometry
    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int WORD_W       = 32;
    localparam int IDX_W        = $clog2(STATE_WORDS);

    // recurrence and tempering constants
    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;
    localparam logic [WORD_W-1:0] HIGH_BIT     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOW_BITS     = 32'h7FFF_FFFF;

    // shared unit operations
    typedef logic [1:0] t_alu_op;
    localparam t_alu_op ALU_MULT   = 2'd0;
    localparam t_alu_op ALU_ADD    = 2'd1;
    localparam t_alu_op ALU_TWIST  = 2'd2;
    localparam t_alu_op ALU_TEMPER = 2'd3;

    // request to the shared unit
    typedef struct packed {
        t_alu_op           op;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
    } t_alu_req;

endpackage

// ===== rtl/core/mtg_ram.sv =====
//------------------------------------------------------------------------------
// mtg_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/mtg_alu.sv =====
//------------------------------------------------------------------------------
// mtg_alu
// Shared arithmetic unit: seed multiply, add, one-word twist and tempering.
//------------------------------------------------------------------------------
module mtg_alu (
    input  mtg_pkg::t_alu_req            i_req,
    output logic [mtg_pkg::WORD_W-1:0]   o_res
);
    import mtg_pkg::*;

    logic [WORD_W-1:0] w_mix;
    logic [WORD_W-1:0] w_y;
    logic [WORD_W-1:0] w_t0;
    logic [WORD_W-1:0] w_t1;
    logic [WORD_W-1:0] w_t2;

    // operand shaping for seed and twist
    assign w_mix = i_req.a ^ (i_req.a >> 30);
    assign w_y   = (i_req.a & HIGH_BIT) | (i_req.b & LOW_BITS);

    // tempering chain
    assign w_t0 = i_req.a ^ (i_req.a >> 11);
    assign w_t1 = w_t0 ^ ((w_t0 << 7) & TEMPER_B);
    assign w_t2 = w_t1 ^ ((w_t1 << 15) & TEMPER_C);

    // result select
    always_comb begin
        case (i_req.op)
            ALU_MULT:   o_res = w_mix * SEED_MULT;
            ALU_ADD:    o_res = i_req.a + i_req.b;
            ALU_TWIST:  o_res = i_req.c ^ (w_y >> 1) ^ (w_y[0] ? TWIST_MATRIX : '0);
            ALU_TEMPER: o_res = w_t2 ^ (w_t2 >> 18);
            default:    o_res = '0;
        endcase
    end

endmodule

// ===== rtl/core/mersenne_twister_generator.sv =====
//------------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 32-bit generator: seeds the 624-word state or returns one tempered
// word per request, twisting each state word just before it is read.
//
//  channel   | direction | tdata              | tuser
//  s_axis    | in        | [31:0] seed        | [0] func (0 seed, 1 generate)
//  m_axis    | out       | [31:0] random_word | -
//
// generate: three reads through the one RAM read port (GEN_A0, GEN_A1, GEN_A2), one
// twist (GEN_TW) and one temper (GEN_OUT) load the output; input is busy until then
// seed: input busy until all words are written, one multiply and one add per word
// reset idles the sequencer and clears the seeded flag; the RAM is left as is, and a
// request before the first seed returns zero through GEN_OUT
// a generate stalls in GEN_OUT while a word waits downstream; meanwhile input is not open
//------------------------------------------------------------------------------
module mersenne_twister_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] seed
    input  logic [0:0]  i_s_axis_tuser,   // [0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [31:0] random_word
);
    import mtg_pkg::*;

`include "assert_macros.svh"

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SEED_W0  = 4'd1;
    localparam logic [3:0] ST_SEED_MUL = 4'd2;
    localparam logic [3:0] ST_SEED_ADD = 4'd3;
    localparam logic [3:0] ST_GEN_A0   = 4'd4;
    localparam logic [3:0] ST_GEN_A1   = 4'd5;
    localparam logic [3:0] ST_GEN_A2   = 4'd6;
    localparam logic [3:0] ST_GEN_TW   = 4'd7;
    localparam logic [3:0] ST_GEN_OUT  = 4'd8;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STATE_WORDS - 1);
    localparam logic [IDX_W-1:0] WRAP_IDX  = IDX_W'(STATE_WORDS - TWIST_OFFSET);
    localparam logic [IDX_W-1:0] OFS_IDX   = IDX_W'(TWIST_OFFSET);

    logic [3:0]        r_state,     n_state;
    logic              r_seeded,    n_seeded;
    logic [IDX_W-1:0]  r_pos,       n_pos;
    logic [IDX_W-1:0]  r_k,         n_k;
    logic [WORD_W-1:0] r_p,         n_p;
    logic [WORD_W-1:0] r_acc,       n_acc;
    logic [WORD_W-1:0] r_wk,        n_wk;
    logic [WORD_W-1:0] r_wn,        n_wn;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_data,  n_out_data;

    logic              w_accept;
    logic              w_out_free;
    logic [IDX_W-1:0]  w_nxt;
    logic [IDX_W-1:0]  w_far;
    t_alu_req          w_alu_req;
    logic [WORD_W-1:0] w_alu_res;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_addr;
    logic [WORD_W-1:0] w_wr_data;
    logic [IDX_W-1:0]  w_rd_addr;
    logic [WORD_W-1:0] w_rd_data;
    logic              w_seed_start;
    logic              w_write_state;

    // handshakes
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // neighbor and far indexes, wrapped around the state
    assign w_nxt = (r_pos == LAST_IDX) ? '0 : r_pos + 1'b1;
    assign w_far = (r_pos < WRAP_IDX) ? r_pos + OFS_IDX : r_pos - WRAP_IDX;

    // state RAM
    mtg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // shared arithmetic unit
    mtg_alu u_alu (
        .i_req (w_alu_req),
        .o_res (w_alu_res)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_seeded    = r_seeded;
        n_pos       = r_pos;
        n_k         = r_k;
        n_p         = r_p;
        n_acc       = r_acc;
        n_wk        = r_wk;
        n_wn        = r_wn;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        w_alu_req   = '{op: ALU_ADD, a: r_acc, b: '0, c: '0};
        w_wr_en     = 1'b0;
        w_wr_addr   = r_k;
        w_wr_data   = w_alu_res;
        w_rd_addr   = r_pos;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (!i_s_axis_tuser[0]) begin
                        n_p     = i_s_axis_tdata;
                        n_state = ST_SEED_W0;
                    end else if (r_seeded) begin
                        n_state = ST_GEN_A0;
                    end else begin
                        n_acc   = '0;
                        n_state = ST_GEN_OUT;
                    end
                end
            end
            ST_SEED_W0: begin
                w_wr_en   = 1'b1;
                w_wr_addr = '0;
                w_wr_data = r_p;
                n_k       = IDX_W'(1);
                n_state   = ST_SEED_MUL;
            end
            ST_SEED_MUL: begin
                w_alu_req = '{op: ALU_MULT, a: r_p, b: '0, c: '0};
                n_acc     = w_alu_res;
                n_state   = ST_SEED_ADD;
            end
            ST_SEED_ADD: begin
                w_alu_req = '{op: ALU_ADD, a: r_acc, b: WORD_W'(r_k), c: '0};
                w_wr_en   = 1'b1;
                w_wr_addr = r_k;
                w_wr_data = w_alu_res;
                n_p       = w_alu_res;
                if (r_k == LAST_IDX) begin
                    n_pos    = '0;
                    n_seeded = 1'b1;
                    n_state  = ST_IDLE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = ST_SEED_MUL;
                end
            end
            ST_GEN_A0: begin
                w_rd_addr = r_pos;
                n_state   = ST_GEN_A1;
            end
            ST_GEN_A1: begin
                w_rd_addr = w_nxt;
                n_wk      = w_rd_data;
                n_state   = ST_GEN_A2;
            end
            ST_GEN_A2: begin
                w_rd_addr = w_far;
                n_wn      = w_rd_data;
                n_state   = ST_GEN_TW;
            end
            ST_GEN_TW: begin
                w_alu_req = '{op: ALU_TWIST, a: r_wk, b: r_wn, c: w_rd_data};
                w_wr_en   = 1'b1;
                w_wr_addr = r_pos;
                w_wr_data = w_alu_res;
                n_acc     = w_alu_res;
                n_state   = ST_GEN_OUT;
            end
            ST_GEN_OUT: begin
                w_alu_req = '{op: ALU_TEMPER, a: r_acc, b: '0, c: '0};
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_alu_res;
                    n_pos       = w_nxt;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seeded    <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seeded    <= n_seeded;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_p        <= n_p;
        r_acc      <= n_acc;
        r_wk       <= n_wk;
        r_wn       <= n_wn;
        r_out_data <= n_out_data;
    end

    // terms for the checks
    assign w_seed_start  = w_accept && !i_s_axis_tuser[0];
    assign w_write_state = (r_state == ST_SEED_W0) || (r_state == ST_SEED_ADD) ||
                           (r_state == ST_GEN_TW);

    // checks
    `ASSERT_ALWAYS(a_pos_range, i_clk, i_rst_n, r_pos <= LAST_IDX)
    `ASSERT_IMPL(a_twist_seeded, i_clk, i_rst_n, r_state == ST_GEN_A0, r_seeded)
    `ASSERT_NEXT(a_seed_start, i_clk, i_rst_n, w_seed_start, r_state == ST_SEED_W0)
    `ASSERT_IMPL(a_write_states, i_clk, i_rst_n, w_wr_en, w_write_state)
    `ASSERT_NEXT(a_out_load, i_clk, i_rst_n, r_state == ST_GEN_OUT && w_out_free, r_out_valid)

endmodule

// ===== dv/mersenne_twister_generator_test.sv =====
//------------------------------------------------------------------------------
// mersenne_twister_generator_test
// Self-checking bench for the MT19937 generator: drives seed and generate
// requests with bursty valid and a stalling output side, predicts every
// tempered word and compares it in order with what the block returns.
//------------------------------------------------------------------------------
module mersenne_twister_generator_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mtg_pkg::*;

    // request kinds carried on tuser
    typedef enum bit {
        FUNC_SEED     = 1'b0,
        FUNC_GENERATE = 1'b1
    } t_func;

    localparam int unsigned ITEM_TARGET = 1150;
    localparam int unsigned IDLE_LIMIT  = 8000;
    localparam int unsigned DRAIN_TAIL  = 32;

    // predicts generator output and holds the words still owed by the block
    class mt_scoreboard;
        bit [WORD_W-1:0] state_mem [STATE_WORDS];
        int unsigned     rd_pos;
        bit [WORD_W-1:0] owed_words [$];
        int unsigned     fail_count;

        function new();
            foreach (state_mem[k]) state_mem[k] = '0;
            rd_pos     = STATE_WORDS + 1;
            fail_count = 0;
        endfunction

        // in-place twist, words wrapping around already updated entries
        function void twist_state();
            int unsigned     nxt;
            int unsigned     far;
            bit [WORD_W-1:0] y;
            bit [WORD_W-1:0] v;
            for (int unsigned k = 0; k < STATE_WORDS; k++) begin
                nxt = (k + 1) % STATE_WORDS;
                far = (k + TWIST_OFFSET) % STATE_WORDS;
                y   = (state_mem[k] & HIGH_BIT) | (state_mem[nxt] & LOW_BITS);
                v   = state_mem[far] ^ (y >> 1);
                if (y[0]) v ^= TWIST_MATRIX;
                state_mem[k] = v;
            end
            rd_pos = 0;
        endfunction

        function bit [WORD_W-1:0] temper_word(bit [WORD_W-1:0] w);
            bit [WORD_W-1:0] y;
            y = w;
            y ^= (y >> 11);
            y ^= (y << 7) & TEMPER_B;
            y ^= (y << 15) & TEMPER_C;
            y ^= (y >> 18);
            return y;
        endfunction

        // called once per accepted request
        function void note_request(t_func func, bit [WORD_W-1:0] seed);
            bit [WORD_W-1:0] p;
            if (func == FUNC_SEED) begin
                state_mem[0] = seed;
                for (int unsigned k = 1; k < STATE_WORDS; k++) begin
                    p = state_mem[k-1];
                    state_mem[k] = SEED_MULT * (p ^ (p >> 30)) + WORD_W'(k);
                end
                rd_pos = STATE_WORDS;
            end else begin
                if (rd_pos >= STATE_WORDS) twist_state();
                owed_words.push_back(temper_word(state_mem[rd_pos]));
                rd_pos++;
            end
        endfunction

        // called once per accepted output word
        function void check_word(bit [WORD_W-1:0] actual);
            bit [WORD_W-1:0] want;
            if (owed_words.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected random word, expected none, actual %08h",
                         $time, actual);
            end else begin
                want = owed_words.pop_front();
                if (actual !== want) begin
                    fail_count++;
                    $display("%0t: random_word mismatch, expected %08h, actual %08h",
                             $time, want, actual);
                end
            end
        endfunction

        function int unsigned pending();
            return owed_words.size();
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata  = '0;    // [31:0] seed
    logic [0:0]  i_s_axis_tuser  = '0;    // [0] func
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;          // [31:0] random_word

    mt_scoreboard sb = new();

    int unsigned items_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned idle_cycles = 0;
    logic [15:0] rx_cycle    = '0;
    int unsigned rx_stall    = 0;

    mersenne_twister_generator dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // output side: check words, stall in stretches with open windows
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_word(o_m_axis_tdata);
        end
        rx_cycle <= rx_cycle + 1'b1;
        if (rx_cycle[8:7] == 2'b00) begin
            i_m_axis_tready <= 1'b1;
        end else if (rx_stall != 0) begin
            i_m_axis_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rx_stall <= $urandom_range(1, 20);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, no handshake for %0d cycles",
                     $time, idle_cycles);
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one request, sent inside a burst or after a random gap
    task automatic send_request(input t_func func, input bit [31:0] seed);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= seed;
        i_s_axis_tuser  <= func;
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        sb.note_request(func, seed);
        items_sent++;
    endtask

    // hold off new requests until every owed word has come back
    task automatic drain_words();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic bit [31:0] pick_seed();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 15);
            1:       return 32'hFFFF_FFFF ^ $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int unsigned run_len;
        bit          long_done;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // generate before any seed returns zero, seed field ignored
        send_request(FUNC_GENERATE, 32'hFFFF_FFFF);
        send_request(FUNC_GENERATE, 32'h0000_0000);
        // extreme and standard seeds
        send_request(FUNC_SEED, 32'h0000_0000);
        repeat (3) send_request(FUNC_GENERATE, $urandom);
        send_request(FUNC_SEED, 32'hFFFF_FFFF);
        repeat (3) send_request(FUNC_GENERATE, $urandom);
        send_request(FUNC_SEED, 32'd5489);
        repeat (2) send_request(FUNC_GENERATE, 32'hFFFF_FFFF);
        send_request(FUNC_SEED, 32'h8000_0000);
        send_request(FUNC_GENERATE, 32'h0000_0000);
        send_request(FUNC_SEED, 32'h7FFF_FFFF);
        send_request(FUNC_GENERATE, 32'h5555_5555);
        send_request(FUNC_SEED, 32'h0000_0001);
        send_request(FUNC_GENERATE, 32'hAAAA_AAAA);

        // let the block run dry once
        drain_words();

        // random part: seeded runs of generates, one long enough to twist again
        long_done = 1'b0;
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 7) == 0) begin
                // noise: loose mix of seeds and generates
                run_len = $urandom_range(1, 8);
                repeat (run_len) send_request(t_func'($urandom_range(0, 1)), pick_seed());
            end else begin
                send_request(FUNC_SEED, pick_seed());
                run_len = long_done ? $urandom_range(1, 60) : 700;
                long_done = 1'b1;
                repeat (run_len) send_request(FUNC_GENERATE, $urandom);
            end
        end

        drain_words();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d random words never arrived", $time, sb.pending());
        end
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mtg_pkg.sv
rtl/core/mtg_ram.sv
rtl/core/mtg_alu.sv
rtl/core/mersenne_twister_generator.sv
dv/mersenne_twister_generator_test.sv
